### sv/rc_pkg.sv
// Package for the radix converter: field widths, register indexes, reset values
// and the base clamping functions.
// No dependencies; used by radix_converter_core.
package rc_pkg;

	localparam int NUM_W      = 31;  // input number width
	localparam int DIG_W      = 4;   // output digit width
	localparam int SRC_W      = 4;   // source_base register width
	localparam int TGT_W      = 5;   // target_base register width
	localparam int CNT_W      = 6;   // digit count width
	localparam int BCD_DIGITS = 10;  // decimal digits of the largest input
	localparam int BCD_W      = BCD_DIGITS * DIG_W;
	localparam int MAX_OUT    = 31;  // most digits in one run

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = 2'd1;

	localparam logic [SRC_W-1:0] SRC_RESET = 4'd10;
	localparam logic [TGT_W-1:0] TGT_RESET = 5'd2;
	localparam logic [SRC_W-1:0] SRC_MIN   = 4'd2;
	localparam logic [SRC_W-1:0] DEC_RADIX = 4'd10;
	localparam logic [TGT_W-1:0] TGT_MIN   = 5'd2;
	localparam logic [TGT_W-1:0] TGT_MAX   = 5'd16;

	typedef logic [DIG_W-1:0] digit_t;

	// Source bases below two act as two, those above ten act as ten.
	function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] b);
		logic [SRC_W-1:0] r;
		r = b;
		if (b < SRC_MIN) r = SRC_MIN;
		else if (b > DEC_RADIX) r = DEC_RADIX;
		return r;
	endfunction

	// Target bases below two act as two, those above sixteen act as sixteen.
	function automatic logic [TGT_W-1:0] clamp_tgt(input logic [TGT_W-1:0] b);
		logic [TGT_W-1:0] r;
		r = b;
		if (b < TGT_MIN) r = TGT_MIN;
		else if (b > TGT_MAX) r = TGT_MAX;
		return r;
	endfunction

endpackage

### sv/radix_converter_core.sv
// Radix converter core: reads the decimal digits of an input number as digits in
// source_base and streams the value's digits in target_base, most significant first.
// Depends on rc_pkg.

// An accepted number is first split into decimal digits by a bit-serial
// double-dabble pass, then weighted by source_base with one multiply-add per
// decimal digit, then saturated to VALUE_BITS. Each target digit then comes from
// a shared divider that handles one nibble of the value per cycle, and each digit
// is delivered through the registered read of the digit store and held while the
// receiver stalls. A new number is taken only when the previous run has been
// fully delivered. Configuration writes are always ready and take effect at once.
module radix_converter_core #(
	parameter int DIGIT_STORE_DEPTH = 32,
	parameter int VALUE_BITS        = 31
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [rc_pkg::NUM_W-1:0]        number,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [rc_pkg::DIG_W-1:0]        digit,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW     = $clog2(DIGIT_STORE_DEPTH);
	localparam int LIMIT  = (DIGIT_STORE_DEPTH < rc_pkg::MAX_OUT) ?
	                        DIGIT_STORE_DEPTH : rc_pkg::MAX_OUT;
	localparam int ND     = (VALUE_BITS + 3) / 4;
	localparam int VW4    = ND * 4;
	localparam int HW     = rc_pkg::NUM_W + rc_pkg::SRC_W;
	localparam int SW     = (VALUE_BITS > rc_pkg::NUM_W) ? VALUE_BITS : rc_pkg::NUM_W;
	localparam int STEP_W = 5;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DAB  = 3'd1;
	localparam logic [2:0] ST_HORN = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_RD   = 3'd5;
	localparam logic [2:0] ST_SHOW = 3'd6;

	logic [2:0]                      state_q;
	logic [STEP_W-1:0]               step_q;
	logic [rc_pkg::SRC_W-1:0]        src_base_q;
	logic [rc_pkg::TGT_W-1:0]        tgt_base_q;
	logic [rc_pkg::NUM_W-1:0]        bin_q;
	logic [rc_pkg::BCD_W-1:0]        bcd_q;
	logic [rc_pkg::NUM_W-1:0]        acc_q;
	logic [VW4-1:0]                  div_q;
	logic [rc_pkg::DIG_W-1:0]        rem_q;
	logic [rc_pkg::CNT_W-1:0]        cnt_q;
	logic [AW-1:0]                   rd_idx_q;
	rc_pkg::digit_t                  rd_data_q;
	rc_pkg::digit_t                  digit_store_q [DIGIT_STORE_DEPTH];

	logic [rc_pkg::SRC_W-1:0]        sb;
	logic [rc_pkg::TGT_W-1:0]        tb;
	logic [rc_pkg::BCD_W-1:0]        bcd_adj;
	logic [HW-1:0]                   horn_sum;
	logic [SW-1:0]                   acc_ext;
	logic [SW-1:0]                   vmax_ext;
	logic [SW-1:0]                   sat_val;
	logic [8:0]                      trial;
	logic [8:0]                      sub_val;
	logic [3:0]                      qnib;
	logic [VW4-1:0]                  quot;
	logic                            div_wr;

	assign sb = rc_pkg::clamp_src(src_base_q);
	assign tb = rc_pkg::clamp_tgt(tgt_base_q);

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_SHOW);
	assign digit        = rd_data_q;
	assign last         = (rd_idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= rc_pkg::SRC_RESET;
			tgt_base_q <= rc_pkg::TGT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rc_pkg::CFG_SOURCE_BASE: src_base_q <= cfg_data[rc_pkg::SRC_W-1:0];
				rc_pkg::CFG_TARGET_BASE: tgt_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Double-dabble correction: every BCD digit of five or more gets three added
	// before the shift, so that the doubling carries into the next decimal digit.
	always_comb begin
		for (int i = 0; i < rc_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			else bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
		end
	end

	// Horner step over the decimal digits, most significant first. Every partial
	// sum is bounded by the final value, which never exceeds the input number.
	assign horn_sum = HW'(acc_q) * HW'(sb) + HW'(bcd_q[rc_pkg::BCD_W-1 -: 4]);

	assign acc_ext  = SW'(acc_q);
	assign vmax_ext = SW'({VALUE_BITS{1'b1}});
	assign sat_val  = (acc_ext > vmax_ext) ? vmax_ext : acc_ext;

	// One nibble of long division by the target base: the remainder stays below
	// the base, so the quotient nibble settles in four restoring steps.
	always_comb begin
		trial = {1'b0, rem_q, div_q[VW4-1 -: 4]};
		sub_val = '0;
		for (int j = 3; j >= 0; j--) begin
			sub_val = 9'(tb) << j;
			if (trial >= sub_val) begin
				trial   = trial - sub_val;
				qnib[j] = 1'b1;
			end else begin
				qnib[j] = 1'b0;
			end
		end
	end

	assign quot   = {div_q[VW4-5:0], qnib};
	assign div_wr = (state_q == ST_DIV) && (step_q == STEP_W'(ND - 1));

	always_ff @(posedge clk) begin
		if (div_wr) digit_store_q[cnt_q[AW-1:0]] <= trial[3:0];
		rd_data_q <= digit_store_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid && !item_stall) begin
						state_q <= ST_DAB;
						step_q  <= '0;
					end
				end
				ST_DAB: begin
					if (step_q == STEP_W'(rc_pkg::NUM_W - 1)) begin
						state_q <= ST_HORN;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_HORN: begin
					if (step_q == STEP_W'(rc_pkg::BCD_DIGITS - 1)) begin
						state_q <= ST_LOAD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
					step_q  <= '0;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					if (div_wr) begin
						cnt_q  <= cnt_q + 1'b1;
						step_q <= '0;
						// A zero value still yields its single digit before stopping.
						if (quot == '0 || (cnt_q + 1'b1) == rc_pkg::CNT_W'(LIMIT)) begin
							state_q  <= ST_RD;
							rd_idx_q <= cnt_q[AW-1:0];
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_RD: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (!result_stall) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				bin_q <= number;
				bcd_q <= '0;
				acc_q <= '0;
			end
			ST_DAB: begin
				bcd_q <= {bcd_adj[rc_pkg::BCD_W-2:0], bin_q[rc_pkg::NUM_W-1]};
				bin_q <= {bin_q[rc_pkg::NUM_W-2:0], 1'b0};
			end
			ST_HORN: begin
				acc_q <= horn_sum[rc_pkg::NUM_W-1:0];
				bcd_q <= {bcd_q[rc_pkg::BCD_W-5:0], 4'd0};
			end
			ST_LOAD: begin
				div_q <= VW4'(sat_val[VALUE_BITS-1:0]);
				rem_q <= '0;
			end
			ST_DIV: begin
				div_q <= quot;
				rem_q <= div_wr ? '0 : trial[3:0];
			end
			default: ;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (state_q == ST_DAB))
		else $error("accepted number did not start conversion");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && last) |=> (state_q == ST_IDLE))
		else $error("block not idle after final digit transfer");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= rc_pkg::CNT_W'(LIMIT)))
		else $error("digit count beyond store limit");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({1'b0, rem_q} < tb))
		else $error("division remainder not below target base");

endmodule
